[rtl/mie_pkg.sv]
// ----------------------------------------------------------------------------
// mie_pkg
// Shared types and constants for the modular inverse block: the microcode
// control word, the datapath status flags and the reset value of the modulus.
// ----------------------------------------------------------------------------
package mie_pkg;

    // Default operand width and the reset value of the modulus register.
    localparam int          WIDTH_DEFAULT = 32;
    localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

    // Width of the microcode step counter.
    localparam int UPC_W = 4;

    // Datapath operations selected by the control word.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_ALIGN,
        OP_DIVBIT,
        OP_INIT,
        OP_SETUP,
        OP_UPDATE,
        OP_FINAL
    } dp_op_t;

    // Jump conditions tested by the sequencer.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_N_ZERO,
        C_CAN_SHIFT,
        C_K_NZ,
        C_R1_ZERO,
        C_OUT_BUSY
    } cond_t;

    // One microcode word: datapath operation, jump condition and jump target.
    typedef struct packed {
        dp_op_t           op;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } ctrl_word_t;

    // Flags the datapath reports back to the sequencer.
    typedef struct packed {
        logic n_zero;
        logic can_shift;
        logic k_nz;
        logic r1_zero;
        logic out_busy;
    } dp_status_t;

endpackage

[rtl/mie_ucode_seq.sv]
// ----------------------------------------------------------------------------
// mie_ucode_seq
// Microcode sequencer: a step counter, a read-only program of control words
// and conditional jumps on the datapath status flags.
// ----------------------------------------------------------------------------
module mie_ucode_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  mie_pkg::dp_status_t status,
    output mie_pkg::ctrl_word_t ctrl,
    output logic                idle
);
    import mie_pkg::*;

    // Program step addresses.
    localparam logic [UPC_W-1:0] ST_WAIT   = UPC_W'(0);
    localparam logic [UPC_W-1:0] ST_CHECK  = UPC_W'(1);
    localparam logic [UPC_W-1:0] ST_RALIGN = UPC_W'(2);
    localparam logic [UPC_W-1:0] ST_RDIV   = UPC_W'(3);
    localparam logic [UPC_W-1:0] ST_INIT   = UPC_W'(4);
    localparam logic [UPC_W-1:0] ST_TEST   = UPC_W'(5);
    localparam logic [UPC_W-1:0] ST_ALIGN  = UPC_W'(6);
    localparam logic [UPC_W-1:0] ST_DIV    = UPC_W'(7);
    localparam logic [UPC_W-1:0] ST_UPDATE = UPC_W'(8);
    localparam logic [UPC_W-1:0] ST_FINAL  = UPC_W'(9);
    localparam logic [UPC_W-1:0] ST_RETURN = UPC_W'(10);

    // The program. The first division reduces the operand modulo n; the
    // loop from the test step to the update step is one Euclid quotient step.
    function automatic ctrl_word_t rom_word(input logic [UPC_W-1:0] addr);
        ctrl_word_t w;
        unique case (addr)
            ST_WAIT:   w = '{op: OP_LOAD,   cond: C_NO_INPUT,  target: ST_WAIT};
            ST_CHECK:  w = '{op: OP_NOP,    cond: C_N_ZERO,    target: ST_FINAL};
            ST_RALIGN: w = '{op: OP_ALIGN,  cond: C_CAN_SHIFT, target: ST_RALIGN};
            ST_RDIV:   w = '{op: OP_DIVBIT, cond: C_K_NZ,      target: ST_RDIV};
            ST_INIT:   w = '{op: OP_INIT,   cond: C_NEVER,     target: ST_WAIT};
            ST_TEST:   w = '{op: OP_SETUP,  cond: C_R1_ZERO,   target: ST_FINAL};
            ST_ALIGN:  w = '{op: OP_ALIGN,  cond: C_CAN_SHIFT, target: ST_ALIGN};
            ST_DIV:    w = '{op: OP_DIVBIT, cond: C_K_NZ,      target: ST_DIV};
            ST_UPDATE: w = '{op: OP_UPDATE, cond: C_ALWAYS,    target: ST_TEST};
            ST_FINAL:  w = '{op: OP_FINAL,  cond: C_OUT_BUSY,  target: ST_FINAL};
            ST_RETURN: w = '{op: OP_NOP,    cond: C_ALWAYS,    target: ST_WAIT};
            default:   w = '{op: OP_NOP,    cond: C_ALWAYS,    target: ST_WAIT};
        endcase
        return w;
    endfunction

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             take;

    assign ctrl = rom_word(upc_reg);
    assign idle = (upc_reg == ST_WAIT);

    // Condition select and next step.
    always_comb
    begin
        unique case (ctrl.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_INPUT:  take = !in_valid;
            C_N_ZERO:    take = status.n_zero;
            C_CAN_SHIFT: take = status.can_shift;
            C_K_NZ:      take = status.k_nz;
            C_R1_ZERO:   take = status.r1_zero;
            C_OUT_BUSY:  take = status.out_busy;
            default:     take = 1'b0;
        endcase
        upc_next = take ? ctrl.target : upc_reg + UPC_W'(1);
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= ST_WAIT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

[rtl/mie_datapath.sv]
// ----------------------------------------------------------------------------
// mie_datapath
// Remainder, coefficient and division registers of the extended Euclid,
// with a shift-and-subtract divider and the output register.
// ----------------------------------------------------------------------------
module mie_datapath #(
    parameter int WIDTH = mie_pkg::WIDTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mie_pkg::ctrl_word_t ctrl,
    input  logic [WIDTH-1:0]    value,
    input  logic [WIDTH-1:0]    modulus,
    input  logic                out_stall,
    output mie_pkg::dp_status_t status,
    output logic [WIDTH-1:0]    inverse,
    output logic                exists,
    output logic                out_valid
);
    import mie_pkg::*;

    localparam int KW = $clog2(WIDTH);

    // Euclid state: remainders, coefficient magnitudes and sign of m0.
    logic [WIDTH-1:0] n_reg,   n_next;
    logic [WIDTH-1:0] r0_reg,  r0_next;
    logic [WIDTH-1:0] r1_reg,  r1_next;
    logic [WIDTH-1:0] m0_reg,  m0_next;
    logic [WIDTH-1:0] m1_reg,  m1_next;
    logic             neg0_reg, neg0_next;

    // Divider state: running remainder, aligned divisor, shift count and the
    // quotient times m1 built up most significant bit first.
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] d_reg,   d_next;
    logic [KW-1:0]    k_reg,   k_next;
    logic [WIDTH-1:0] acc_reg, acc_next;

    // Output register.
    logic [WIDTH-1:0] inverse_reg, inverse_next;
    logic             exists_reg,  exists_next;
    logic             out_valid_reg, out_valid_next;

    logic [WIDTH:0]   d_dbl;
    logic             can_shift;
    logic             fits;
    logic [WIDTH-1:0] rem_sub;
    logic [WIDTH-1:0] acc_dbl;
    logic [WIDTH-1:0] acc_add;
    logic [WIDTH-1:0] m_sum;
    logic [WIDTH-1:0] m_red;
    logic             ok;
    logic [WIDTH-1:0] inv_calc;
    logic             out_busy;

    // Divider and result arithmetic.
    always_comb
    begin
        d_dbl     = {d_reg, 1'b0};
        can_shift = (d_dbl <= {1'b0, rem_reg});
        fits      = (d_reg <= rem_reg);
        rem_sub   = rem_reg - d_reg;
        acc_dbl   = {acc_reg[WIDTH-2:0], 1'b0};
        acc_add   = acc_dbl + m1_reg;
        m_sum     = m0_reg + acc_reg;
        m_red     = (m0_reg == n_reg) ? '0 : m0_reg;
        ok        = (n_reg != '0) && (r0_reg == WIDTH'(1));
        if (!ok)
        begin
            inv_calc = '0;
        end
        else if (neg0_reg && (m_red != '0))
        begin
            inv_calc = n_reg - m_red;
        end
        else
        begin
            inv_calc = m_red;
        end
        out_busy = out_valid_reg && out_stall;
    end

    assign status = '{n_zero:    (n_reg == '0),
                      can_shift: can_shift,
                      k_nz:      (k_reg != '0),
                      r1_zero:   (r1_reg == '0),
                      out_busy:  out_busy};

    // Operation decoder.
    always_comb
    begin
        n_next       = n_reg;
        r0_next      = r0_reg;
        r1_next      = r1_reg;
        m0_next      = m0_reg;
        m1_next      = m1_reg;
        neg0_next    = neg0_reg;
        rem_next     = rem_reg;
        d_next       = d_reg;
        k_next       = k_reg;
        acc_next     = acc_reg;
        inverse_next = inverse_reg;
        exists_next  = exists_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (ctrl.op)
            OP_NOP:
            begin
            end
            OP_LOAD:
            begin
                rem_next = value;
                d_next   = modulus;
                n_next   = modulus;
                k_next   = '0;
                acc_next = '0;
            end
            OP_ALIGN:
            begin
                if (can_shift)
                begin
                    d_next = d_dbl[WIDTH-1:0];
                    k_next = k_reg + KW'(1);
                end
            end
            OP_DIVBIT:
            begin
                if (fits)
                begin
                    rem_next = rem_sub;
                    acc_next = acc_add;
                end
                else
                begin
                    acc_next = acc_dbl;
                end
                if (k_reg != '0)
                begin
                    d_next = {1'b0, d_reg[WIDTH-1:1]};
                    k_next = k_reg - KW'(1);
                end
            end
            OP_INIT:
            begin
                // The sign flag starts set so that the first update leaves
                // m0 = 1 marked positive; the signs alternate from there.
                r0_next   = n_reg;
                r1_next   = rem_reg;
                m0_next   = '0;
                m1_next   = WIDTH'(1);
                neg0_next = 1'b1;
            end
            OP_SETUP:
            begin
                rem_next = r0_reg;
                d_next   = r1_reg;
                k_next   = '0;
                acc_next = '0;
            end
            OP_UPDATE:
            begin
                r0_next   = r1_reg;
                r1_next   = rem_reg;
                m0_next   = m1_reg;
                m1_next   = m_sum;
                neg0_next = !neg0_reg;
            end
            OP_FINAL:
            begin
                if (!out_busy)
                begin
                    inverse_next   = inv_calc;
                    exists_next    = ok;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        r0_reg      <= r0_next;
        r1_reg      <= r1_next;
        m0_reg      <= m0_next;
        m1_reg      <= m1_next;
        neg0_reg    <= neg0_next;
        rem_reg     <= rem_next;
        d_reg       <= d_next;
        k_reg       <= k_next;
        acc_reg     <= acc_next;
        inverse_reg <= inverse_next;
        exists_reg  <= exists_next;
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign inverse   = inverse_reg;
    assign exists    = exists_reg;
    assign out_valid = out_valid_reg;

endmodule

[rtl/modular_inverse_ext_euclid.sv]
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid
// Modular inverse of one operand by the extended Euclidean algorithm, run by
// a small microcode program over a shift-and-subtract datapath.
// ----------------------------------------------------------------------------
// Each input transaction carries an operand; one output transaction returns
// its inverse modulo the configured modulus in 0 to modulus-1 with exists set,
// or inverse 0 with exists clear when the gcd is not 1 (modulus 1 gives 0
// with exists set). The block works on one operand at a time and takes the
// next one once the previous result has been written to the output register
// and the program is back at its first step. Every division runs in the shared
// shift-and-subtract unit one bit per cycle: each quotient step aligns the
// divisor, subtracts bit by bit and then does its bookkeeping. The user must
// write the modulus through cfg_we and cfg_wdata only while the block is idle;
// the block itself does not enforce this. The modulus resets to 1000000007.
module modular_inverse_ext_euclid #(
    parameter int WIDTH = mie_pkg::WIDTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [WIDTH-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [WIDTH-1:0] value,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [WIDTH-1:0] inverse,
    output logic             exists
);
    import mie_pkg::*;

    localparam logic [WIDTH-1:0] MOD_RST = MODULUS_RESET[WIDTH-1:0];

    logic [WIDTH-1:0] modulus_reg;
    ctrl_word_t       ctrl;
    dp_status_t       status;
    logic             seq_idle;

    // Modulus configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_RST;
        end
        else if (cfg_we)
        begin
            modulus_reg <= cfg_wdata;
        end
    end

    // An operand is taken only while the program waits at its first step.
    assign in_stall = !seq_idle;

    mie_ucode_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .ctrl     (ctrl),
        .idle     (seq_idle)
    );

    mie_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .value     (value),
        .modulus   (modulus_reg),
        .out_stall (out_stall),
        .status    (status),
        .inverse   (inverse),
        .exists    (exists),
        .out_valid (out_valid)
    );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the modular inverse block. An in-bench extended
// Euclid computes the expected inverse and exists flag for every accepted
// operand under the current modulus. Directed tests cover the reset modulus,
// a modulus of one, the all-ones modulus and the longest quotient chain.
// Random phases then change the modulus between runs of random operands,
// with random idle cycles on the input side and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_top;

    import mie_pkg::*;

    localparam int W = WIDTH_DEFAULT;

    // Consecutive Fibonacci numbers give the longest run of quotient steps.
    localparam logic [W-1:0] FIB_45 = 32'd1134903170;
    localparam logic [W-1:0] FIB_46 = 32'd1836311903;
    localparam logic [W-1:0] FIB_47 = 32'd2971215073;

    // A few well-known primes used as moduli.
    localparam logic [W-1:0] PRIME_NTT  = 32'd998244353;
    localparam logic [W-1:0] PRIME_TOP  = 32'd4294967291;
    localparam logic [W-1:0] PRIME_MERS = 32'd2147483647;

    localparam int PHASE_COUNT  = 12;
    localparam int PHASE_ITEMS  = 105;
    localparam int SETTLE_CYCLES = 400;

    // One expected result together with the operand and modulus behind it.
    typedef struct packed {
        logic [W-1:0] operand;
        logic [W-1:0] modulus;
        logic [W-1:0] inverse;
        logic         exists;
    } inverse_txn_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         cfg_we    = 1'b0;
    logic [W-1:0] cfg_wdata = '0;
    logic         in_valid  = 1'b0;
    logic [W-1:0] value     = '0;
    logic         out_stall = 1'b0;
    logic         in_stall;
    logic         out_valid;
    logic [W-1:0] inverse;
    logic         exists;

    // Testbench copy of the modulus register and the queue of expected results.
    logic [W-1:0] modulus_now = MODULUS_RESET[W-1:0];
    inverse_txn_t pending_inverses[$];
    int           error_count = 0;
    int           stall_left  = 0;
    bit           in_quiet    = 1'b0;
    bit           out_quiet   = 1'b0;

    modular_inverse_ext_euclid #(
        .WIDTH(W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .inverse   (inverse),
        .exists    (exists)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit, well beyond the slowest legal run.
    initial
    begin
        #(100_000_000);
        $display("tb_top: errors");
        $finish;
    end

    // Extended Euclid with a signed coefficient, normalised into 0 .. n-1.
    function automatic inverse_txn_t calc_inverse(input logic [W-1:0] a,
                                                  input logic [W-1:0] n);
        inverse_txn_t res;
        logic [63:0]  r_prev;
        logic [63:0]  r_cur;
        logic [63:0]  r_next;
        logic [63:0]  quot;
        longint       c_prev;
        longint       c_cur;
        longint       c_next;
        res.operand = a;
        res.modulus = n;
        res.inverse = '0;
        res.exists  = 1'b0;
        if (n == '0)
            return res;
        r_prev = n;
        r_cur  = a % n;
        c_prev = 0;
        c_cur  = 1;
        while (r_cur != 0)
        begin
            quot   = r_prev / r_cur;
            r_next = r_prev - quot * r_cur;
            c_next = c_prev - longint'(quot) * c_cur;
            r_prev = r_cur;
            r_cur  = r_next;
            c_prev = c_cur;
            c_cur  = c_next;
        end
        if (r_prev != 1)
            return res;
        c_prev = c_prev % longint'(n);
        if (c_prev < 0)
            c_prev = c_prev + longint'(n);
        res.inverse = c_prev[W-1:0];
        res.exists  = 1'b1;
        return res;
    endfunction

    // Idle cycles before the next transaction on either side.
    function automatic int idle_cycles(input bit quiet);
        if (quiet)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    // Print one line for a mismatch and count it.
    task automatic report_mismatch(input string msg);
        error_count++;
        $display("%0t tb_top mismatch: %s", $time, msg);
    endtask

    // Output side: compare every accepted result, then draw the next stall.
    always @(posedge clk)
    begin
        inverse_txn_t exp_txn;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_inverses.size() == 0)
                report_mismatch($sformatf("unexpected result inverse=%0d exists=%0b",
                                          inverse, exists));
            else
            begin
                exp_txn = pending_inverses.pop_front();
                if (inverse !== exp_txn.inverse)
                    report_mismatch($sformatf("a=%0d n=%0d inverse %0d, expected %0d",
                                              exp_txn.operand, exp_txn.modulus,
                                              inverse, exp_txn.inverse));
                if (exists !== exp_txn.exists)
                    report_mismatch($sformatf("a=%0d n=%0d exists %0b, expected %0b",
                                              exp_txn.operand, exp_txn.modulus,
                                              exists, exp_txn.exists));
            end
            stall_left = idle_cycles(out_quiet);
        end
        out_stall <= (stall_left != 0);
        if (stall_left != 0)
            stall_left--;
    end

    // Offer one operand, hold it until accepted, then record its expected result.
    task automatic send_operand(input logic [W-1:0] operand);
        int gap;
        gap = idle_cycles(in_quiet);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= operand;
        do
            @(posedge clk);
        while (in_stall);
        pending_inverses.push_back(calc_inverse(operand, modulus_now));
    endtask

    // Stop sending and wait until every expected result has been returned.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_inverses.size() != 0);
    endtask

    // Modulus write; only called while the block is idle.
    task automatic write_modulus(input logic [W-1:0] n);
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_we      <= 1'b0;
        modulus_now = n;
    endtask

    // Modulus for one random phase; the extremes get phases of their own.
    function automatic logic [W-1:0] pick_modulus(input int phase);
        logic [W-1:0] m;
        m = '0;
        case (phase % 6)
            0: m = $urandom;
            1: m = $urandom_range(1, 64);
            2: m[$urandom_range(0, W - 1)] = 1'b1;
            3:
            begin
                case ($urandom_range(0, 3))
                    0:       m = PRIME_NTT;
                    1:       m = PRIME_TOP;
                    2:       m = PRIME_MERS;
                    default: m = FIB_47;
                endcase
            end
            4: m = (phase < 6) ? W'(1) : '1;
            default: m = $urandom | W'(1);
        endcase
        if (m == '0)
            m = W'(1);
        return m;
    endfunction

    // Operand mix: wide random, reduced, shared factors and values near the edges.
    function automatic logic [W-1:0] pick_operand(input logic [W-1:0] n);
        logic [W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = $urandom % n;
            6:          v = W'($urandom_range(2, 16)) * W'($urandom >> 5);
            7:
            begin
                case ($urandom_range(0, 5))
                    0:       v = '0;
                    1:       v = W'(1);
                    2:       v = n - W'(1);
                    3:       v = n;
                    4:       v = n + W'(1);
                    default: v = '1;
                endcase
            end
            8:          v = $urandom_range(0, 255);
            default:    v = n - W'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    // Reset modulus: zero, one, two, operands at and around the modulus, all ones.
    task automatic test_reset_modulus();
        send_operand('0);
        send_operand(W'(1));
        send_operand(W'(2));
        send_operand(modulus_now - W'(1));
        send_operand(modulus_now);
        send_operand(modulus_now + W'(1));
        send_operand('1);
        wait_drained();
    endtask

    // Modulus of one: every operand has inverse zero with exists set.
    task automatic test_modulus_one();
        write_modulus(W'(1));
        send_operand('0);
        send_operand(W'(1));
        send_operand('1);
        wait_drained();
    endtask

    // All-ones modulus is composite, so some operands have no inverse.
    task automatic test_modulus_all_ones();
        write_modulus('1);
        send_operand(W'(2));
        send_operand(W'(3));
        send_operand(32'd65537);
        send_operand('1 - W'(1));
        send_operand('1);
        wait_drained();
    endtask

    // Fibonacci neighbours force the longest chain of quotient steps.
    task automatic test_long_quotient_chain();
        write_modulus(FIB_47);
        send_operand(FIB_46);
        send_operand(FIB_45);
        send_operand(FIB_47 - W'(1));
        wait_drained();
    endtask

    // Random operands under a sequence of moduli, idling varied per phase.
    task automatic test_random_moduli();
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            in_quiet  = (phase % 4 == 1) || (phase % 4 == 3);
            out_quiet = (phase % 4 >= 2);
            write_modulus(pick_modulus(phase));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_operand(pick_operand(modulus_now));
                // Now and then let the pipeline run completely dry.
                if ($urandom_range(0, 63) == 0)
                    wait_drained();
            end
            wait_drained();
        end
    endtask

    // Test sequence.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_modulus();
        test_modulus_one();
        test_modulus_all_ones();
        test_long_quotient_chain();
        test_random_moduli();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
